// ===== hw/rtl/fbc_pkg.sv =====
// frustum box culling: shared types and constants
// plane register layout, register indexes, verdict codes and datapath widths
// no dependencies
package fbc_pkg;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = COORD_W + COEF_W;
    // three products plus the shifted offset stay below 2^32 in magnitude
    localparam int SUM_W   = PROD_W + 2;
    localparam int FRAC_N  = 14;
    localparam int AXES    = 3;
    localparam int PLANES  = 6;

    localparam int REG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int IDX_W   = 3;

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_NEAR   = 3'd0;
    localparam reg_idx_t REG_FAR    = 3'd1;
    localparam reg_idx_t REG_LEFT   = 3'd2;
    localparam reg_idx_t REG_RIGHT  = 3'd3;
    localparam reg_idx_t REG_TOP    = 3'd4;
    localparam reg_idx_t REG_BOTTOM = 3'd5;
    localparam reg_idx_t REG_FAST   = 3'd6;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_OUTSIDE = 2'd0;
    localparam verdict_t VERDICT_INSIDE  = 2'd1;
    localparam verdict_t VERDICT_PARTIAL = 2'd2;

    // packed plane register, d in the top 16 bits
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COEF_W-1:0]  nz;
        logic signed [COEF_W-1:0]  ny;
        logic signed [COEF_W-1:0]  nx;
    } plane_t;

endpackage

// ===== hw/rtl/frustum_box_culling.sv =====
// frustum box culling top level: box against up to six planes, apb register port
// depends on fbc_pkg
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  box in    | min_x min_y min_z max_x max_y max_z     | start while busy low
//  verdict   | verdict                                 | done, one cycle, no backpressure
//  registers | psel penable pwrite paddr pwdata prdata | apb write, pready always high
//
// one box per cycle; done and verdict are registered: the box transaction is captured
// in the input register, which feeds the plane products and sums straight into the result
// register. busy is never raised, so start may stay high.
// reset clears the plane registers, fast mode and the strobes.
module frustum_box_culling #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                start,
    output logic                                busy,
    input  logic signed [fbc_pkg::COORD_W-1:0]  min_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]  min_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]  min_z,
    input  logic signed [fbc_pkg::COORD_W-1:0]  max_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]  max_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]  max_z,

    output logic                                done,
    output fbc_pkg::verdict_t                   verdict,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbc_pkg::ADDR_W-1:0]          paddr,
    input  logic [fbc_pkg::REG_W-1:0]           pwdata,
    output logic [fbc_pkg::REG_W-1:0]           prdata,
    output logic                                pready
);

    import fbc_pkg::*;

    plane_t   plane_reg [PLANES];
    logic     fast_mode_reg;

    logic     valid_reg;
    logic signed [COORD_W-1:0] lo_reg [AXES];
    logic signed [COORD_W-1:0] hi_reg [AXES];

    logic     done_reg;
    verdict_t verdict_reg;
    verdict_t verdict_next;

    logic     cfg_write;
    reg_idx_t cfg_idx;
    logic     accept;

    logic signed [COEF_W-1:0] norm      [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0] prod_lo   [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0] prod_hi   [PLANE_COUNT][AXES];
    logic signed [SUM_W-1:0]  sum_max   [PLANE_COUNT];
    logic signed [SUM_W-1:0]  sum_min   [PLANE_COUNT];
    logic signed [SUM_W-1:0]  sum_fast  [PLANE_COUNT];
    logic [PLANE_COUNT-1:0]   all_behind;
    logic [PLANE_COUNT-1:0]   all_front;
    logic [PLANE_COUNT-1:0]   fast_behind;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
            fast_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_NEAR, REG_FAR, REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM:
                begin
                    plane_reg[cfg_idx] <= plane_t'(pwdata);
                end
                REG_FAST:
                begin
                    fast_mode_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_NEAR, REG_FAR, REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM:
            begin
                prdata = plane_reg[cfg_idx];
            end
            REG_FAST:
            begin
                prdata = {{(REG_W-1){1'b0}}, fast_mode_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg[0] <= min_x;
            lo_reg[1] <= min_y;
            lo_reg[2] <= min_z;
            hi_reg[0] <= max_x;
            hi_reg[1] <= max_y;
            hi_reg[2] <= max_z;
        end
    end

    // per plane: the largest and smallest corner value split per axis,
    // and the corner the normal points at for the fast test
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            norm[p][0] = plane_reg[p].nx;
            norm[p][1] = plane_reg[p].ny;
            norm[p][2] = plane_reg[p].nz;
            sum_max[p]  = SUM_W'(signed'({plane_reg[p].d, {FRAC_N{1'b0}}}));
            sum_min[p]  = sum_max[p];
            sum_fast[p] = sum_max[p];
            for (int a = 0; a < AXES; a++)
            begin
                prod_lo[p][a] = norm[p][a] * lo_reg[a];
                prod_hi[p][a] = norm[p][a] * hi_reg[a];
                if (prod_lo[p][a] > prod_hi[p][a])
                begin
                    sum_max[p] = sum_max[p] + SUM_W'(prod_lo[p][a]);
                    sum_min[p] = sum_min[p] + SUM_W'(prod_hi[p][a]);
                end
                else
                begin
                    sum_max[p] = sum_max[p] + SUM_W'(prod_hi[p][a]);
                    sum_min[p] = sum_min[p] + SUM_W'(prod_lo[p][a]);
                end
                // negative normal picks the min coordinate, even for an inverted box
                if (norm[p][a][COEF_W-1])
                begin
                    sum_fast[p] = sum_fast[p] + SUM_W'(prod_lo[p][a]);
                end
                else
                begin
                    sum_fast[p] = sum_fast[p] + SUM_W'(prod_hi[p][a]);
                end
            end
            all_behind[p]  = sum_max[p][SUM_W-1];
            all_front[p]   = !sum_min[p][SUM_W-1];
            fast_behind[p] = sum_fast[p][SUM_W-1];
        end
    end

    always_comb
    begin
        if (fast_mode_reg)
        begin
            verdict_next = (|fast_behind) ? VERDICT_OUTSIDE : VERDICT_PARTIAL;
        end
        else if (|all_behind)
        begin
            verdict_next = VERDICT_OUTSIDE;
        end
        else if (&all_front)
        begin
            verdict_next = VERDICT_INSIDE;
        end
        else
        begin
            verdict_next = VERDICT_PARTIAL;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule
